/* hw/rtl/wmd_pkg.sv */
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared types and constants of the windowed mode decimator.
// ----------------------------------------------------------------------------
package wmd_pkg;

   // Width and reset value of the window size register.
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd16;

   // Cells per group of the registered hit tree.
   localparam int GROUP_SIZE = 8;

   // Per-cycle commands broadcast along the cell chain.
   typedef struct packed {
      logic step;   // count a matching sample
      logic shift;  // move every entry one cell down, insert at the head
      logic clear;  // drop all entries
   } wmd_ctrl_type;

endpackage

/* hw/rtl/wmd_req_if.sv */
// ----------------------------------------------------------------------------
// wmd_req_if
// Sample channel: valid/ready handshake carrying one stream value per item.
// ----------------------------------------------------------------------------
interface wmd_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

/* hw/rtl/wmd_rsp_if.sv */
// ----------------------------------------------------------------------------
// wmd_rsp_if
// Result channel: valid/ready handshake carrying one window mode per item.
// ----------------------------------------------------------------------------
interface wmd_rsp_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] mode_value;

   modport source (output valid, output mode_value, input ready);
   modport sink   (input valid, input mode_value, output ready);
endinterface

/* hw/rtl/wmd_cell.sv */
// ----------------------------------------------------------------------------
// wmd_cell
// One table entry: a distinct value, its count and a valid bit. Compares the
// broadcast sample and takes its upstream neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module wmd_cell
   import wmd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_W     = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wmd_ctrl_type           ctrl,
   input  logic [VALUE_WIDTH-1:0] sample,
   input  logic                   prev_valid,
   input  logic [VALUE_WIDTH-1:0] prev_value,
   input  logic [COUNT_W-1:0]     prev_count,
   output logic                   valid,
   output logic [VALUE_WIDTH-1:0] value,
   output logic [COUNT_W-1:0]     count,
   output logic                   hit,
   output logic [COUNT_W-1:0]     hit_count
);

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   assign hit       = valid_ff && (value_ff == sample);
   assign hit_count = hit ? count_ff + 1'b1 : '0;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = prev_valid;
         value_in = prev_value;
         count_in = prev_count;
      end else if (ctrl.step && hit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign count = count_ff;

endmodule

/* hw/rtl/windowed_mode_decimator_unit.sv */
// ----------------------------------------------------------------------------
// windowed_mode_decimator_unit
// Decimating mode filter over back-to-back windows of signed samples.
//
// The sample stream is cut into windows of csr window_size items (0 acts as
// 1, sizes above MAX_WINDOW act as MAX_WINDOW; a new size applies at once).
// At the last item of each window one result item carries the most frequent
// value of that window, the smallest value on a tie; other items give none.
// A compare step checks the sample against every table cell and registers
// the per-group hit tree; an update step folds the groups, inserts a new
// value and updates the running mode; the next sample can be taken as the
// update step completes. A finished result waits in an output register;
// only the last item of the next window stalls while it is still untaken.
// The table empties at a window's end in the same cycle through per-cell
// valid bits, so there is no clearing pass after reset or between windows.
// ----------------------------------------------------------------------------
module windowed_mode_decimator_unit
   import wmd_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [CFG_W-1:0] csr_write_data,
   wmd_req_if.sink          req_item,
   wmd_rsp_if.source        rsp_item
);

   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SZ_W    = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
   localparam int NGROUPS = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
   // Results wider than 32 bits keep only their low word.
   localparam logic [VALUE_WIDTH-1:0] OUT_MASK =
      (VALUE_WIDTH > 32) ? VALUE_WIDTH'(64'hFFFF_FFFF) : '1;

   // Configuration
   logic [CFG_W-1:0] window_size_ff;

   // Pipeline control and sample hold
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic [VALUE_WIDTH-1:0] sample_ff;
   logic                   req_accept;

   // Cell chain
   wmd_ctrl_type           ctrl;
   logic [MAX_WINDOW-1:0]  cell_valid;
   logic [VALUE_WIDTH-1:0] cell_value     [MAX_WINDOW];
   logic [COUNT_W-1:0]     cell_count     [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]  cell_hit;
   logic [COUNT_W-1:0]     cell_hit_count [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]  chain_valid;
   logic [VALUE_WIDTH-1:0] chain_value    [MAX_WINDOW];
   logic [COUNT_W-1:0]     chain_count    [MAX_WINDOW];

   // Hit tree
   logic [NGROUPS-1:0] grp_hit_ff, grp_hit_in;
   logic [COUNT_W-1:0] grp_count_ff [NGROUPS];
   logic [COUNT_W-1:0] grp_count_in [NGROUPS];
   logic               hit_any;
   logic [COUNT_W-1:0] hit_cnt;

   // Window and running mode
   logic [COUNT_W-1:0]     items_ff, items_in, items_next;
   logic [VALUE_WIDTH-1:0] best_value_ff, best_value_in, best_value_next;
   logic [COUNT_W-1:0]     best_count_ff, best_count_in, best_count_next;
   logic [SZ_W-1:0]        eff_size;
   logic                   table_full;
   logic                   found;
   logic                   take_new;
   logic [COUNT_W-1:0]     new_count;
   logic                   last;
   logic                   s2_done;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   // --- configuration: the user must write it only while the block is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
      end else if (csr_write_en) begin
         window_size_ff <= csr_write_data;
      end
   end

   // Clamp the size to 1..MAX_WINDOW.
   always_comb begin
      eff_size = SZ_W'(window_size_ff);
      if (eff_size == '0) begin
         eff_size = SZ_W'(1);
      end else if (eff_size > SZ_W'(MAX_WINDOW)) begin
         eff_size = SZ_W'(MAX_WINDOW);
      end
   end

   // --- input handshake: take the next sample as the current one finishes
   assign req_accept     = req_item.valid && req_item.ready;
   assign req_item.ready = !s1_valid_ff && (!s2_valid_ff || s2_done);

   assign s1_valid_in = req_accept;
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_valid_ff) begin
         s2_valid_in = 1'b1;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Hold the sample until its update step ends.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_item.sample_value;
      end
   end

   // --- cell chain: the head takes the new value with a count of one
   assign chain_valid[0] = 1'b1;
   assign chain_value[0] = sample_ff;
   assign chain_count[0] = COUNT_W'(1);

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign chain_valid[i] = cell_valid[i-1];
         assign chain_value[i] = cell_value[i-1];
         assign chain_count[i] = cell_count[i-1];
      end

      wmd_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .COUNT_W     (COUNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sample     (sample_ff),
         .prev_valid (chain_valid[i]),
         .prev_value (chain_value[i]),
         .prev_count (chain_count[i]),
         .valid      (cell_valid[i]),
         .value      (cell_value[i]),
         .count      (cell_count[i]),
         .hit        (cell_hit[i]),
         .hit_count  (cell_hit_count[i])
      );
   end

   // --- hit tree, first level: fold each group of cells in the compare cycle
   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         grp_hit_in[g]   = 1'b0;
         grp_count_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < MAX_WINDOW) begin
               grp_hit_in[g]   = grp_hit_in[g] | cell_hit[g * GROUP_SIZE + k];
               grp_count_in[g] = grp_count_in[g] | cell_hit_count[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         grp_hit_ff   <= grp_hit_in;
         grp_count_ff <= grp_count_in;
      end
   end

   // Second level: at most one cell matches, so OR gives its new count.
   always_comb begin
      hit_cnt = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         hit_cnt = hit_cnt | grp_count_ff[g];
      end
   end
   assign hit_any = |grp_hit_ff;

   // --- update cycle: insert, rank against the running mode, close window
   assign table_full = cell_valid[MAX_WINDOW-1];
   // A new value at a full table is not counted.
   assign found      = hit_any || !table_full;
   assign new_count  = hit_any ? hit_cnt : COUNT_W'(1);
   assign take_new   = found &&
                       ((new_count > best_count_ff) ||
                        ((new_count == best_count_ff) &&
                         ($signed(sample_ff) < $signed(best_value_ff))));

   assign best_value_next = take_new ? sample_ff : best_value_ff;
   assign best_count_next = take_new ? new_count : best_count_ff;
   assign items_next      = items_ff + 1'b1;
   assign last            = SZ_W'(items_next) >= eff_size;
   // Hold the closing item while the previous result is still untaken.
   assign s2_done         = s2_valid_ff && !(last && rsp_valid_ff && !rsp_item.ready);

   assign ctrl.step  = s1_valid_ff;
   assign ctrl.shift = s2_done && !hit_any && !table_full;
   assign ctrl.clear = s2_done && last;

   always_comb begin
      items_in      = items_ff;
      best_value_in = best_value_ff;
      best_count_in = best_count_ff;
      if (s2_done) begin
         if (last) begin
            items_in      = '0;
            best_value_in = '0;
            best_count_in = '0;
         end else begin
            items_in      = items_next;
            best_value_in = best_value_next;
            best_count_in = best_count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff      <= '0;
         best_value_ff <= '0;
         best_count_ff <= '0;
      end else begin
         items_ff      <= items_in;
         best_value_ff <= best_value_in;
         best_count_ff <= best_count_in;
      end
   end

   // --- result register: drop on take, load on window close
   assign rsp_valid_in = (rsp_valid_ff && !rsp_item.ready) || (s2_done && last);
   assign rsp_value_in = (s2_done && last) ? (best_value_next & OUT_MASK) : rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_item.valid      = rsp_valid_ff;
   assign rsp_item.mode_value = rsp_value_ff;

`ifndef ASSERT_OFF
   // Compare and update cycles of one item never overlap.
   a_stage_excl: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("compare and update stages active together");

   // A taken sample is compared in the very next cycle.
   a_accept_compare: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item not in compare stage");

   // Distinct values: a sample matches at most one cell.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(cell_hit))
      else $error("sample matches more than one table cell");

   // Entries fill from the head of the chain without gaps.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (MAX_WINDOW'(cell_valid + 1'b1) & cell_valid) == '0)
      else $error("table cells not filled from the head");

   // Closing a window empties the table and loads a result.
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (cell_valid == '0) && rsp_valid_ff && (items_ff == '0))
      else $error("window close left state behind");
`endif

endmodule

/* sim/wmd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmd_checker
// Watches the sample, result and csr ports of the mode decimator, keeps its
// own window table and running mode, and compares every result item with the
// oldest predicted mode.
// ----------------------------------------------------------------------------
module wmd_checker
   import wmd_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [CFG_W-1:0] csr_write_data,
   wmd_req_if               req_mon,
   wmd_rsp_if               rsp_mon,
   output int               fail_count,
   output int               pending_count,
   output int               item_count,
   output int               result_count
);

   localparam int REPORT_CAP = 30;

   logic [CFG_W-1:0]              window_reg;
   logic signed [VALUE_WIDTH-1:0] slot_value [MAX_WINDOW];
   int                            slot_count [MAX_WINDOW];
   int                            slots_used;
   int                            window_fill;
   logic signed [VALUE_WIDTH-1:0] lead_value;
   int                            lead_count;
   logic signed [VALUE_WIDTH-1:0] mode_queue [$];

   task automatic clear_window();
      for (int i = 0; i < MAX_WINDOW; i++) begin
         slot_count[i] = 0;
      end
      slots_used  = 0;
      window_fill = 0;
      lead_value  = '0;
      lead_count  = 0;
   endtask

   // Count one sample into the window table; close the window when full.
   task automatic absorb_sample(input logic signed [VALUE_WIDTH-1:0] v);
      int span;
      int hit;
      int cnt;
      if (window_reg == 0) begin
         span = 1;
      end else if (window_reg > MAX_WINDOW) begin
         span = MAX_WINDOW;
      end else begin
         span = int'(window_reg);
      end
      hit = -1;
      cnt = 0;
      for (int i = 0; i < slots_used; i++) begin
         if (hit < 0 && slot_value[i] == v) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         slot_count[hit]++;
         cnt = slot_count[hit];
      end else if (slots_used < MAX_WINDOW) begin
         slot_value[slots_used] = v;
         slot_count[slots_used] = 1;
         slots_used++;
         cnt = 1;
      end
      // strict greater-than, smallest value wins an equal count
      if (cnt > 0 && (cnt > lead_count || (cnt == lead_count && v < lead_value))) begin
         lead_count = cnt;
         lead_value = v;
      end
      window_fill++;
      if (window_fill >= span) begin
         mode_queue.push_back(lead_value);
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_reg = WINDOW_SIZE_RESET;
         clear_window();
         mode_queue.delete();
         fail_count   = 0;
         item_count   = 0;
         result_count = 0;
      end else begin
         if (csr_write_en) begin
            window_reg = csr_write_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            item_count++;
            absorb_sample(req_mon.sample_value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (mode_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_CAP) begin
                  $display("%0t: unexpected result, expected none, actual mode_value %0d",
                           $time, rsp_mon.mode_value);
               end
            end else begin
               if (rsp_mon.mode_value !== mode_queue[0]) begin
                  fail_count++;
                  if (fail_count <= REPORT_CAP) begin
                     $display("%0t: mode_value mismatch, expected %0d, actual %0d",
                              $time, mode_queue[0], rsp_mon.mode_value);
                  end
               end
               void'(mode_queue.pop_front());
            end
         end
      end
      pending_count = mode_queue.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the windowed mode decimator: directed windows with
// extreme values and ties, then random windows over many window sizes, with
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
   import wmd_pkg::*;

   localparam int MAX_WINDOW    = 64;
   localparam int VALUE_WIDTH   = 32;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int SETTLE_CYCLES = 8;     // block needs compare and update steps per item plus output reg
   localparam int HOLD_CYCLES   = 300;   // long receiver stall
   localparam int DOG_LIMIT     = 3000;  // cycles with no item moving on either side
   localparam int PAL_MAX       = 8;

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [CFG_W-1:0] csr_write_data;

   wmd_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_item ();
   wmd_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_item ();

   int fail_count;
   int pending_count;
   int item_count;
   int result_count;

   // per-phase idle limits for each side; zero gives a stretch with no idling
   int  send_gap_max = 9;
   int  recv_gap_max = 9;
   bit  hold_rsp     = 1'b0;
   int  settings_used = 0;
   int  dog_count    = 0;

   logic signed [VALUE_WIDTH-1:0] palette [PAL_MAX];
   int                            pal_len;

   windowed_mode_decimator_unit #(
      .MAX_WINDOW  (MAX_WINDOW),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_item       (req_item),
      .rsp_item       (rsp_item)
   );

   wmd_checker #(
      .MAX_WINDOW  (MAX_WINDOW),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_mon        (req_item),
      .rsp_mon        (rsp_item),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .item_count     (item_count),
      .result_count   (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if no item moves for too long.
   always @(posedge clock) begin
      if (reset || (req_item.valid && req_item.ready) || (rsp_item.valid && rsp_item.ready)) begin
         dog_count <= 0;
      end else begin
         dog_count <= dog_count + 1;
         if (dog_count + 1 >= DOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, DOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: draw a wait per result item, hold off once for a long stretch on request.
   initial begin : receiver
      int gap;
      bit hold_done;
      hold_done      = 1'b0;
      rsp_item.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_item.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         gap = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
         if (gap > 0) begin
            rsp_item.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_item.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_item.valid && rsp_item.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Offer one sample after a random gap and hold it until it is taken.
   task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] v);
      int gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_item.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item.valid        <= 1'b1;
      req_item.sample_value <= v;
      @(posedge clock);
      while (!(req_item.valid && req_item.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted mode, then let the pipeline drain.
   task automatic wait_quiet();
      req_item.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the window size; only ever done with the block idle.
   task automatic set_window(input logic [CFG_W-1:0] size);
      wait_quiet();
      csr_write_en   <= 1'b1;
      csr_write_data <= size;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      settings_used++;
   endtask

   // Refill the value palette: extremes, small signed values, full random words.
   task automatic refresh_palette();
      pal_len = $urandom_range(1, PAL_MAX);
      for (int i = 0; i < PAL_MAX; i++) begin
         case ($urandom_range(0, 5))
            0: palette[i] = $urandom;
            1: palette[i] = 32'sh8000_0000;
            2: palette[i] = 32'sh7fff_ffff;
            3: palette[i] = '0;
            4: palette[i] = -1;
            default: palette[i] = $signed($urandom_range(0, 6)) - 3;
         endcase
      end
   endtask

   // Mostly repeat palette values so counts climb and ties occur.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_sample();
      if ($urandom_range(0, 9) < 2) begin
         return $urandom;
      end
      return palette[$urandom_range(0, pal_len - 1)];
   endfunction

   initial begin : stimulus
      logic signed [VALUE_WIDTH-1:0] tie_window [16];
      logic [CFG_W-1:0]              sweep [10];
      logic [CFG_W-1:0]              size;
      int                            span;
      int                            count;
      int                            sent;
      int                            phase;

      tie_window = '{32'sh7fff_ffff, 5, -7, 5, -7, 32'sh8000_0000, 32'sh7fff_ffff, 0,
                     -1, 1, 2, 3, 4, 6, 8, 9};
      sweep      = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3, 7'd5, 7'd8, 7'd63};

      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_write_data        = '0;
      req_item.valid        = 1'b0;
      req_item.sample_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset size of 16, three-way tie of 0x7fffffff, 5 and -7, smallest wins.
      foreach (tie_window[i]) send_sample(tie_window[i]);

      // Size zero acts as a one-item window.
      set_window(7'd0);
      send_sample(32'sh8000_0000);

      // Shrink the size mid-window: two items held, next item closes the window.
      set_window(7'd3);
      send_sample(32'sh7fff_ffff);
      send_sample(-1);
      set_window(7'd1);
      send_sample(0);

      // Long output stall with a steady sender: fills the output and stalls input.
      set_window(7'd2);
      send_gap_max = 0;
      hold_rsp     = 1'b1;
      refresh_palette();
      for (int i = 0; i < 60; i++) send_sample(pick_sample());
      send_gap_max = 9;

      // Random windows across a sweep of sizes, then random sizes.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < $size(sweep)) begin
            size = sweep[phase];
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: size = CFG_W'($urandom_range(1, 12));
               7, 8:                size = CFG_W'($urandom_range(13, 64));
               default:             size = ($urandom_range(0, 1) == 0) ? 7'd0
                                                : CFG_W'($urandom_range(65, 127));
            endcase
         end
         set_window(size);
         span  = (size == 0) ? 1 : ((size > MAX_WINDOW) ? MAX_WINDOW : int'(size));
         count = span * $urandom_range(1, 3) + $urandom_range(0, span - 1);
         send_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 9;
         recv_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 9;
         for (int i = 0; i < count; i++) begin
            if (i % span == 0) begin
               refresh_palette();
            end
            send_sample(pick_sample());
         end
         sent += count;
         phase++;
      end

      // Drain and give the verdict.
      wait_quiet();
      repeat (20) @(negedge clock);
      $display("Run covered %0d sample items over %0d window size writes (sizes 0 to 127,",
               item_count, settings_used);
      $display("mid-window resize, long output stall); %0d window modes compared.",
               result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
